// File: src/sitda_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and conversion functions of the decimal text converter.
package sitda_pkg;

	localparam int VALUE_W    = 32;
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int CHAR_W     = 6;
	localparam int STEP_BITS  = 8;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
	localparam logic [IDX_W-1:0]  IDX_TOP    = IDX_W'(MAX_DIGITS - 1);

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [MAX_DIGITS-1:0] digits_t;

	// Conversion state as it travels down the pipeline.
	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} conv_t;

	// Eight shift-and-add-3 steps: move eight binary bits into the BCD field.
	function automatic conv_t dabble_steps(conv_t c);
		conv_t r;
		r = c;
		for (int j = 0; j < STEP_BITS; j++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (r.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			{r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		end
		return r;
	endfunction

	// Index of the most significant non-zero digit, zero when all digits are zero.
	function automatic logic [IDX_W-1:0] top_digit(logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
				idx = IDX_W'(d);
			end
		end
		return idx;
	endfunction

endpackage

// File: src/sitda_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the number input and the character output.
interface sitda_num_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sitda_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitda_text_if;
	logic                          valid;
	logic                          ready;
	logic [sitda_pkg::CHAR_W-1:0]  text_char;
	logic                          last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: src/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Signed 32-bit integer to decimal ASCII text converter: top level.
//
// Each word taken on num is a signed 32-bit integer; the block sends its
// decimal text on text, one ASCII character per word, most significant
// first: a '-' for negative values, then the digits without leading zeros
// ('0' alone for zero), with last_char set on the final character. The most
// negative value prints in full. A number enters a five-stage pipeline
// (magnitude, then four stages of eight shift-and-add-3 steps each) and then
// loads a character serialiser that drives text straight from its
// registers. A number gives from 1 up to 11 characters (ten digits and a
// sign), and that single output serialiser sets the sustained rate; the
// following numbers convert meanwhile, so a new text starts in the cycle
// after the previous last character is taken. Nothing is kept from one
// number to the next.
module signed_int_to_decimal_ascii (
	input  logic          clk,
	input  logic          arst_n,
	sitda_num_if.sink     num,
	sitda_text_if.source  text
);

	// Pipeline valids and payloads.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	sitda_pkg::conv_t conv_s1, conv_s2, conv_s3, conv_s4, conv_s5;

	// Serialiser state.
	logic                        busy_q;
	logic                        sign_q;
	logic [sitda_pkg::IDX_W-1:0] idx_q;
	sitda_pkg::digits_t          digits_q;

	logic out_take;
	logic out_done;
	logic load;
	logic adv;
	logic [sitda_pkg::VALUE_W-1:0] raw;
	logic [sitda_pkg::VALUE_W-1:0] mag;

	// A character leaves when the sink takes it; the run ends on its last one.
	assign out_take = text.valid && text.ready;
	assign out_done = out_take && text.last_char;

	// Load the serialiser when it is free or about to finish its run.
	assign load = !busy_q || out_done;

	// Advance the whole pipeline unless its last stage holds a word it cannot hand on.
	assign adv       = !v_s5 || load;
	assign num.ready = adv;

	// Form the magnitude as unsigned: the most negative value wraps to 2^31 exactly.
	assign raw = num.value;
	assign mag = raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;

	// Valid bits travel with the data; hold everything on a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= num.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload stages: capture the magnitude, then shift eight bits per stage into BCD.
	always_ff @(posedge clk) begin
		if (adv) begin
			conv_s1.neg <= raw[sitda_pkg::VALUE_W-1];
			conv_s1.bcd <= '0;
			conv_s1.bin <= mag;
			conv_s2     <= sitda_pkg::dabble_steps(conv_s1);
			conv_s3     <= sitda_pkg::dabble_steps(conv_s2);
			conv_s4     <= sitda_pkg::dabble_steps(conv_s3);
			conv_s5     <= sitda_pkg::dabble_steps(conv_s4);
		end
	end

	// Serialiser: send the sign first if any, then step down from the top digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= v_s5;
			sign_q <= v_s5 && conv_s5.neg;
			idx_q  <= sitda_pkg::top_digit(conv_s5.bcd);
		end else if (out_take) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= conv_s5.bcd;
		end
	end

	// Drive the current character straight from the serialiser registers.
	assign text.valid     = busy_q;
	assign text.text_char = sign_q ? sitda_pkg::CHAR_MINUS
	                               : sitda_pkg::CHAR_ZERO + {2'b00, digits_q[idx_q]};
	assign text.last_char = !sign_q && (idx_q == '0);

	// A pending sign only exists inside an active run.
	a_sign_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sign_q |-> busy_q)
		else $error("sign pending with no active run");

	// The digit pointer never leaves the digit array.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= sitda_pkg::IDX_TOP))
		else $error("digit index out of range");

	// A stalled last stage keeps its word until the serialiser takes it.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !load) |=> (v_s5 && $stable(conv_s5)))
		else $error("pipeline word lost on a stall");

	// Every character sent is a minus sign or a decimal digit.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.text_char == sitda_pkg::CHAR_MINUS ||
			(text.text_char >= sitda_pkg::CHAR_ZERO &&
			 text.text_char <= sitda_pkg::CHAR_ZERO + 6'd9)))
		else $error("character outside the decimal set");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the signed integer to decimal ASCII converter.
module tb_top;

	localparam int CLK_HALF    = 5;
	localparam int RST_CYCLES  = 12;
	// Slowest run: about 110 numbers of 11 characters each, with the receiver
	// mostly stalled; take that many times over.
	localparam int CYCLE_LIMIT = 200000;
	// Time from num to the first character, plus margin.
	localparam int DRAIN_WAIT  = 16;

	// One character word as it leaves the block.
	typedef struct packed {
		logic [sitda_pkg::CHAR_W-1:0] text_char;
		logic                         last_char;
	} text_word_t;

	logic clk;
	logic arst_n;

	sitda_num_if  num_ch ();
	sitda_text_if text_ch ();

	signed_int_to_decimal_ascii u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	// Numbers waiting to be offered, and characters the block still owes us.
	logic signed [sitda_pkg::VALUE_W-1:0] pending_num_q[$];
	text_word_t                           owed_text_q[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int nums_taken;
	int negs_taken;
	int chars_checked;
	int mismatches;
	int cycle_count;

	always #CLK_HALF clk = ~clk;

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Work out the text of one number and queue its characters, most
	// significant first. The magnitude is taken 33 bits wide so that the
	// most negative value does not wrap.
	function automatic void predict_text(
		input logic signed [sitda_pkg::VALUE_W-1:0] num_value);
		logic [sitda_pkg::VALUE_W:0] mag;
		logic [3:0]                  digs[sitda_pkg::MAX_DIGITS];
		int                          ndig;
		text_word_t                  w;
		mag = num_value[sitda_pkg::VALUE_W-1]
			? ((sitda_pkg::VALUE_W+1)'(1) << sitda_pkg::VALUE_W) - {1'b0, num_value}
			: {1'b0, num_value};
		ndig = 0;
		// Zero still yields one digit, since the loop body runs once.
		do begin
			digs[ndig] = 4'(mag % 10);
			mag        = mag / 10;
			ndig++;
		end while (mag != 0);
		if (num_value[sitda_pkg::VALUE_W-1]) begin
			w.text_char = sitda_pkg::CHAR_MINUS;
			w.last_char = 1'b0;
			owed_text_q.push_back(w);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			w.text_char = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digs[i]);
			w.last_char = (i == 0);
			owed_text_q.push_back(w);
		end
	endfunction

	// Pick a random number, leaning towards a spread of digit counts and
	// the edges between them rather than only full 32-bit noise.
	function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_number();
		int unsigned mag;
		int unsigned lo;
		int unsigned hi;
		int          ndig;
		logic        neg;
		neg = $urandom_range(1);
		case ($urandom_range(3))
			0: begin
				return $urandom;
			end
			1: begin
				mag = $urandom_range(99);
			end
			2: begin
				// Power of ten, or one below it.
				ndig = $urandom_range(9);
				mag  = 1;
				for (int i = 0; i < ndig; i++) begin
					mag = mag * 10;
				end
				if ($urandom_range(1)) begin
					mag = mag - 1;
				end
			end
			default: begin
				ndig = $urandom_range(1, sitda_pkg::MAX_DIGITS);
				lo   = 1;
				for (int i = 1; i < ndig; i++) begin
					lo = lo * 10;
				end
				hi  = (ndig == sitda_pkg::MAX_DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
				lo  = (ndig == 1) ? 0 : lo;
				mag = $urandom_range(hi, lo);
			end
		endcase
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// Driver: offer the next pending number, hold it until taken, and
	// predict the text of every number the block accepts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch.valid <= 1'b0;
			num_ch.value <= '0;
		end else begin
			if (num_ch.valid && num_ch.ready) begin
				predict_text(num_ch.value);
				nums_taken++;
				if (num_ch.value[sitda_pkg::VALUE_W-1]) begin
					negs_taken++;
				end
			end
			if (!num_ch.valid || num_ch.ready) begin
				if (pending_num_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					num_ch.valid <= 1'b1;
					num_ch.value <= pending_num_q.pop_front();
				end else begin
					num_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall the receiver at random and check each character word
	// against the oldest one owed.
	always @(posedge clk or negedge arst_n) begin
		text_word_t want;
		if (!arst_n) begin
			text_ch.ready <= 1'b0;
		end else begin
			text_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			if (text_ch.valid && text_ch.ready) begin
				chars_checked++;
				if (owed_text_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d last %b",
						text_ch.text_char, text_ch.last_char));
				end else begin
					want = owed_text_q.pop_front();
					if (text_ch.text_char !== want.text_char) begin
						report_mismatch($sformatf("text_char %0d, expected %0d",
							text_ch.text_char, want.text_char));
					end
					if (text_ch.last_char !== want.last_char) begin
						report_mismatch($sformatf("last_char %b, expected %b (char %0d)",
							text_ch.last_char, want.last_char, want.text_char));
					end
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters still owed",
				cycle_count, owed_text_q.size());
			$display("FAIL signed_int_to_decimal_ascii");
			$finish;
		end
	end

	// Hold the sender until every number is taken and every character has
	// come back.
	task automatic drain_all();
		while (pending_num_q.size() != 0 || num_ch.valid || owed_text_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			pending_num_q.push_back(random_number());
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		num_ch.valid  = 1'b0;
		num_ch.value  = '0;
		text_ch.ready = 1'b0;
		tx_idle_pct   = 9;
		rx_idle_pct   = 74;
		nums_taken    = 0;
		negs_taken    = 0;
		chars_checked = 0;
		mismatches    = 0;
		cycle_count   = 0;
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero, single digits, some digit-count edges, both ends
		// of the range including the most negative value, and all bits
		// toggled by zero and minus one.
		pending_num_q.push_back(32'sd0);
		pending_num_q.push_back(32'sd1);
		pending_num_q.push_back(-32'sd1);
		pending_num_q.push_back(32'sd9);
		pending_num_q.push_back(32'sd10);
		pending_num_q.push_back(-32'sd10);
		pending_num_q.push_back(32'sd100);
		pending_num_q.push_back(-32'sd5);
		pending_num_q.push_back(32'sd123456789);
		pending_num_q.push_back(-32'sd987654321);
		pending_num_q.push_back(32'sd999999999);
		pending_num_q.push_back(-32'sd999999999);
		pending_num_q.push_back(32'sd1000000000);
		pending_num_q.push_back(-32'sd1000000000);
		pending_num_q.push_back(32'sh7FFF_FFFF);
		pending_num_q.push_back(32'sh8000_0000);
		pending_num_q.push_back(32'sh8000_0001);
		pending_num_q.push_back(32'sh5555_5555);
		pending_num_q.push_back(32'shAAAA_AAAA);
		queue_random(31);
		// Pause the sender until the block has emptied out completely.
		drain_all();

		tx_idle_pct = 74;
		rx_idle_pct = 9;
		queue_random(30);
		drain_all();

		// Full throughput both ways.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(30);
		drain_all();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d numbers (%0d negative) into %0d checked characters",
			nums_taken, negs_taken, chars_checked);
		$display("Idling mixes: sender-light/receiver-heavy, the reverse, then none; %0d mismatches",
			mismatches);
		if (mismatches == 0 && owed_text_q.size() == 0) begin
			$display("PASS signed_int_to_decimal_ascii");
		end else begin
			$display("FAIL signed_int_to_decimal_ascii");
		end
		$finish;
	end

endmodule

// File: files.f
src/sitda_pkg.sv
src/sitda_ifs.sv
src/signed_int_to_decimal_ascii.sv
dv/tb_top.sv
